// ===== rtl/core/size_class_block_allocator_macros.svh =====
// assertion macros shared by the allocator checker
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scba assertion failed");

// next-cycle implication, disabled while in reset
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scba assertion failed");

`endif

// ===== rtl/core/scba_pkg.sv =====
// shared types, constants and helpers of the size-class block allocator
package scba_pkg;

  localparam int NUM_CLASSES     = 6;
  localparam int MAX_BLOCKS      = 1024;
  localparam int MIN_CLASS_SHIFT = 16;
  localparam logic [40:0] TOP_SIZE_CAP = 41'd2097152;

  localparam int STORE_DEPTH = NUM_CLASSES * MAX_BLOCKS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 11;
  localparam int CLS_W       = 3;
  localparam int OFF_W       = 40;
  localparam int REQ_W       = 32;
  localparam int DIV_STEPS   = OFF_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_OVERSIZE  = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;
  localparam logic [2:0] ST_FREED     = 3'd5;
  localparam logic [2:0] ST_BAD_FREE  = 3'd6;
  localparam logic [2:0] ST_REBUILT   = 3'd7;

  localparam logic CFG_ARENA_TOTAL = 1'b0;
  localparam logic CFG_MAX_BLOCK   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop_done;
    logic div_step;
    logic layout_step;
    logic fill_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic go_pop;
    logic go_rebuild;
    logic div_last;
    logic layout_last;
    logic fill_last;
  } sts_t;

  function automatic logic [40:0] class_size(input logic [CLS_W-1:0] ci);
    class_size = 41'd1 << (MIN_CLASS_SHIFT + int'(ci));
  endfunction

endpackage

// ===== rtl/core/scba_ram.sv =====
// generic single-write, single-read ram with registered read data
module scba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/scba_ctrl.sv =====
// sequencing state machine of the allocator
module scba_ctrl import scba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_LAYOUT = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE) || sts_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.accept      = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.go_pop) begin
          state_d = S_POP;
        end else if (accept && sts_i.go_rebuild) begin
          state_d = S_DIV;
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_LAYOUT;
        end
      end
      S_LAYOUT: begin
        cmd_o.layout_step = 1'b1;
        if (sts_i.layout_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/scba_datapath.sv =====
// class tables, free-stack ram, divider and result register
module scba_datapath import scba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [OFF_W-1:0]   cfg_data_i,
  input  logic [1:0]         opcode_i,
  input  logic [REQ_W-1:0]   request_bytes_i,
  input  logic [CLS_W-1:0]   class_number_i,
  input  logic [BLK_W-1:0]   block_number_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [CLS_W-1:0]   granted_class_o,
  output logic [BLK_W-1:0]   granted_block_o,
  output logic [OFF_W-1:0]   byte_offset_o,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  logic [OFF_W-1:0] total_q;
  logic [REQ_W-1:0] maxb_q;

  logic [CNT_W-1:0] depth_q  [NUM_CLASSES];
  logic [CNT_W-1:0] blocks_q [NUM_CLASSES];
  logic [OFF_W-1:0] base_q   [NUM_CLASSES];
  logic [CLS_W-1:0] active_q;
  logic             en_q;

  logic [CLS_W-1:0] n_q;
  logic [OFF_W-1:0] quo_q;
  logic [2:0]       rem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [CLS_W-1:0] lay_cls_q;
  logic [OFF_W-1:0] off_q;
  logic [CLS_W-1:0] fill_cls_q;
  logic [CNT_W-1:0] fill_idx_q;
  logic [CLS_W-1:0] pop_cls_q;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [CLS_W-1:0] gcls_q;
  logic [BLK_W-1:0] gblk_q;
  logic [OFF_W-1:0] goff_q;

  logic [CLS_W-1:0] n_fit;
  logic             fit_found;
  logic [CLS_W-1:0] fit_ci;
  logic             pop_ok;
  logic             free_bad;
  logic [3:0]       div_r;
  logic             div_bit;
  logic [OFF_W-1:0] lay_shift;
  logic [CNT_W-1:0] lay_cnt;
  logic [OFF_W-1:0] lay_off_d;
  logic             fill_room;
  logic [BLK_W-1:0] ram_rdata;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BLK_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic             res_load;
  logic [2:0]       res_status;

  // classes that the current max allows
  always_comb begin
    n_fit = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (class_size(CLS_W'(i)) <= {9'd0, maxb_q} && class_size(CLS_W'(i)) <= TOP_SIZE_CAP) begin
        n_fit = CLS_W'(i + 1);
      end
    end
  end

  // smallest active class that holds the request
  always_comb begin
    fit_found = 1'b0;
    fit_ci    = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (CLS_W'(i) < active_q && {9'd0, request_bytes_i} <= class_size(CLS_W'(i))) begin
        fit_found = 1'b1;
        fit_ci    = CLS_W'(i);
      end
    end
  end

  assign pop_ok = en_q && (request_bytes_i != '0) && fit_found && (depth_q[fit_ci] != '0);

  always_comb begin
    free_bad = 1'b1;
    if (en_q && class_number_i < active_q) begin
      free_bad = ({1'b0, block_number_i} >= blocks_q[class_number_i]) ||
                 (depth_q[class_number_i] >= blocks_q[class_number_i]);
    end
  end

  // restoring divide step, divisor is the class count
  assign div_r   = {rem_q, quo_q[OFF_W-1]};
  assign div_bit = div_r >= {1'b0, n_q};

  // per-class block count, saturated
  assign lay_shift = quo_q >> (MIN_CLASS_SHIFT + int'(lay_cls_q));
  assign lay_cnt   = (lay_shift > OFF_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : lay_shift[CNT_W-1:0];
  assign lay_off_d = off_q + (OFF_W'(lay_cnt) << (MIN_CLASS_SHIFT + int'(lay_cls_q)));

  assign fill_room = fill_idx_q < blocks_q[fill_cls_q];

  assign sts_o.out_busy    = out_valid_q && out_stall_i;
  assign sts_o.go_pop      = (opcode_i == OP_ALLOC) && pop_ok;
  assign sts_o.go_rebuild  = (opcode_i == OP_REBUILD) && (n_fit != '0);
  assign sts_o.div_last    = dcnt_q == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts_o.layout_last = lay_cls_q == n_q - 1'b1;
  assign sts_o.fill_last   = !fill_room && (fill_cls_q == n_q - 1'b1);

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {fill_cls_q, fill_idx_q[BLK_W-1:0]};
    ram_wdata = fill_idx_q[BLK_W-1:0];
    if (cmd_i.fill_step && fill_room) begin
      ram_we = 1'b1;
    end else if (cmd_i.accept && opcode_i == OP_FREE && !free_bad) begin
      ram_we    = 1'b1;
      ram_waddr = {class_number_i, depth_q[class_number_i][BLK_W-1:0]};
      ram_wdata = block_number_i;
    end
  end

  assign ram_raddr = {fit_ci, depth_q[fit_ci][BLK_W-1:0] - 1'b1};

  scba_ram #(
    .WIDTH(BLK_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.accept && sts_o.go_pop),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // result of an item that finishes at its accept
  always_comb begin
    res_load   = 1'b0;
    res_status = ST_BAD_FREE;
    if (cmd_i.accept) begin
      case (opcode_i)
        OP_ALLOC: begin
          res_load = !pop_ok;
          if (!en_q) begin
            res_status = ST_DISABLED;
          end else if (request_bytes_i == '0) begin
            res_status = ST_ZERO;
          end else if (!fit_found) begin
            res_status = ST_OVERSIZE;
          end else begin
            res_status = ST_EXHAUSTED;
          end
        end
        OP_FREE: begin
          res_load   = 1'b1;
          res_status = free_bad ? ST_BAD_FREE : ST_FREED;
        end
        OP_REBUILD: begin
          res_load   = (n_fit == '0);
          res_status = ST_REBUILT;
        end
        default: begin
          res_load   = 1'b1;
          res_status = ST_BAD_FREE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pop_cls_q  <= fit_ci;
      n_q        <= n_fit;
      quo_q      <= total_q;
      rem_q      <= '0;
      dcnt_q     <= '0;
      lay_cls_q  <= '0;
      off_q      <= '0;
      fill_cls_q <= '0;
      fill_idx_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[OFF_W-2:0], div_bit};
      rem_q  <= div_bit ? 3'(div_r - {1'b0, n_q}) : div_r[2:0];
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.layout_step) begin
      lay_cls_q <= lay_cls_q + 1'b1;
      off_q     <= lay_off_d;
    end
    if (cmd_i.fill_step) begin
      if (fill_room) begin
        fill_idx_q <= fill_idx_q + 1'b1;
      end else begin
        fill_cls_q <= fill_cls_q + 1'b1;
        fill_idx_q <= '0;
      end
    end
    if (res_load) begin
      status_q <= res_status;
      gcls_q   <= '0;
      gblk_q   <= '0;
      goff_q   <= '0;
    end else if (cmd_i.pop_done) begin
      status_q <= ST_GRANTED;
      gcls_q   <= pop_cls_q;
      gblk_q   <= ram_rdata;
      goff_q   <= base_q[pop_cls_q] +
                  (OFF_W'(ram_rdata) << (MIN_CLASS_SHIFT + int'(pop_cls_q)));
    end else if (cmd_i.fill_step && sts_o.fill_last) begin
      status_q <= ST_REBUILT;
      gcls_q   <= '0;
      gblk_q   <= '0;
      goff_q   <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      maxb_q      <= REQ_W'(TOP_SIZE_CAP);
      active_q    <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        depth_q[i]  <= '0;
        blocks_q[i] <= '0;
        base_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ARENA_TOTAL: total_q <= cfg_data_i;
          CFG_MAX_BLOCK:   maxb_q  <= cfg_data_i[REQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && opcode_i == OP_REBUILD) begin
        active_q <= '0;
        en_q     <= 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          depth_q[i]  <= '0;
          blocks_q[i] <= '0;
          base_q[i]   <= '0;
        end
      end
      if (cmd_i.accept && sts_o.go_pop) begin
        depth_q[fit_ci] <= depth_q[fit_ci] - 1'b1;
      end
      if (cmd_i.accept && opcode_i == OP_FREE && !free_bad) begin
        depth_q[class_number_i] <= depth_q[class_number_i] + 1'b1;
      end
      if (cmd_i.layout_step) begin
        blocks_q[lay_cls_q] <= lay_cnt;
        depth_q[lay_cls_q]  <= lay_cnt;
        base_q[lay_cls_q]   <= off_q;
        if (sts_o.layout_last && lay_off_d != '0) begin
          active_q <= n_q;
          en_q     <= 1'b1;
        end
      end
      if (out_valid_q && out_stall_i) begin
        out_valid_q <= 1'b1;
      end else begin
        out_valid_q <= res_load || cmd_i.pop_done || (cmd_i.fill_step && sts_o.fill_last);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_class_o = gcls_q;
  assign granted_block_o = gblk_q;
  assign byte_offset_o   = goff_q;

endmodule

// ===== rtl/core/size_class_block_allocator.sv =====
// top level of the power-of-two size-class block allocator
// usage
//   input channel: in_valid_i / in_stall_o carry one word (opcode, request_bytes,
//   class_number, block_number); a word is taken when valid is high and stall low
//   output channel: out_valid_o / out_stall_i carry one result word per input word
//   config: cfg_we_i writes arena total (index 0) or max block size (index 1);
//   new values only matter at the next rebuild word
// how results are formed
//   free and rejected allocates: result registered at the accept edge
//   granted allocate: result loaded from the registered free-stack ram read
//   rebuild: the bit-serial class-count divider, then the layout class by class,
//   then the ram fill of each class stack entry by entry
// reset
//   block disabled, no classes, max block size 2 MiB, output empty
// stall
//   a result held by out_stall_i stays put and no new word is taken until it goes
module size_class_block_allocator import scba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [OFF_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [REQ_W-1:0]   request_bytes_i,
  input  logic [CLS_W-1:0]   class_number_i,
  input  logic [BLK_W-1:0]   block_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [CLS_W-1:0]   granted_class_o,
  output logic [BLK_W-1:0]   granted_block_o,
  output logic [OFF_W-1:0]   byte_offset_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, pop wait, divide, layout, fill
  scba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // tables, stacks and the result register
  scba_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .request_bytes_i(request_bytes_i),
    .class_number_i (class_number_i),
    .block_number_i (block_number_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .granted_class_o(granted_class_o),
    .granted_block_o(granted_block_o),
    .byte_offset_o  (byte_offset_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== rtl/core/scba_checker.sv =====
// port-level checker of the allocator and its bind
`include "size_class_block_allocator_macros.svh"

module scba_checker import scba_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       status_o,
  input logic [CLS_W-1:0] granted_class_o,
  input logic [BLK_W-1:0] granted_block_o,
  input logic [OFF_W-1:0] byte_offset_o
);

  // held result does not move
  `SCBA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(byte_offset_o))
  // no word taken while a result is stuck
  `SCBA_ASSERT_IMP(a_no_take, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)
  // only grants carry block data
  `SCBA_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid_o && status_o != ST_GRANTED, granted_class_o == '0 && granted_block_o == '0 && byte_offset_o == '0)
  // granted class exists
  `SCBA_ASSERT_IMP(a_cls, clk_i, rst_ni, out_valid_o && status_o == ST_GRANTED, granted_class_o < CLS_W'(NUM_CLASSES))

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .granted_class_o(granted_class_o),
  .granted_block_o(granted_block_o),
  .byte_offset_o  (byte_offset_o)
);

// ===== tb/tb.sv =====
// self-checking testbench of the size-class block allocator
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int LONG_HOLD    = 200;

  typedef struct packed {
    logic [2:0]       status;
    logic [CLS_W-1:0] cls;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] offset;
  } result_word_t;

  // expected-result store plus its own copy of the allocator state
  class alloc_scoreboard;
    logic [OFF_W-1:0] arena_total;
    logic [31:0]      max_block;
    logic [BLK_W-1:0] stack_mem [NUM_CLASSES][MAX_BLOCKS];
    int unsigned      depth [NUM_CLASSES];
    int unsigned      n_blocks [NUM_CLASSES];
    logic [63:0]      base [NUM_CLASSES];
    int unsigned      n_active;
    bit               enabled;
    result_word_t     pending_q [$];
    int               mismatches;
    int               status_seen [8];

    function new();
      arena_total = '0;
      max_block = 32'd2097152;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_layout();
    endfunction

    function void clear_layout();
      foreach (depth[i]) begin
        depth[i] = 0;
        n_blocks[i] = 0;
        base[i] = '0;
      end
      n_active = 0;
      enabled = 0;
    endfunction

    function void write_reg(logic idx, logic [OFF_W-1:0] data);
      if (idx == CFG_ARENA_TOTAL) arena_total = data;
      else max_block = data[31:0];
    endfunction

    function logic [63:0] size_of(int ci);
      return 64'd1 << (MIN_CLASS_SHIFT + ci);
    endfunction

    function void relayout();
      int n;
      logic [63:0] share, cnt, off;
      clear_layout();
      if (arena_total == 0 || max_block == 0) return;
      n = 0;
      while (n < NUM_CLASSES && size_of(n) <= {32'd0, max_block} &&
             size_of(n) <= 64'(TOP_SIZE_CAP))
        n++;
      if (n == 0) return;
      share = {24'd0, arena_total} / n;
      off = '0;
      for (int ci = 0; ci < n; ci++) begin
        cnt = share / size_of(ci);
        if (cnt > MAX_BLOCKS) cnt = MAX_BLOCKS;
        n_blocks[ci] = cnt;
        base[ci] = off;
        off += cnt * size_of(ci);
        for (int b = 0; b < int'(cnt); b++) stack_mem[ci][b] = b;
        depth[ci] = cnt;
      end
      if (off == 0) begin
        clear_layout();
        return;
      end
      n_active = n;
      enabled = 1;
    endfunction

    // works out the result of one accepted word and queues it
    function result_word_t note_word(logic [1:0] op, logic [31:0] req,
                                     logic [2:0] cls, logic [9:0] blk);
      result_word_t r;
      int ci;
      r = '0;
      if (op == OP_REBUILD) begin
        relayout();
        r.status = ST_REBUILT;
      end else if (op == OP_ALLOC) begin
        if (!enabled) r.status = ST_DISABLED;
        else if (req == 0) r.status = ST_ZERO;
        else begin
          ci = 0;
          while (ci < n_active && size_of(ci) < {32'd0, req}) ci++;
          if (ci >= n_active) r.status = ST_OVERSIZE;
          else if (depth[ci] == 0) r.status = ST_EXHAUSTED;
          else begin
            depth[ci]--;
            r.status = ST_GRANTED;
            r.cls = ci;
            r.blk = stack_mem[ci][depth[ci]];
            r.offset = 40'(base[ci] + 64'(r.blk) * size_of(ci));
          end
        end
      end else if (op == OP_FREE) begin
        if (!enabled || cls >= n_active || blk >= n_blocks[cls] ||
            depth[cls] >= n_blocks[cls])
          r.status = ST_BAD_FREE;
        else begin
          stack_mem[cls][depth[cls]] = blk;
          depth[cls]++;
          r.status = ST_FREED;
        end
      end else begin
        r.status = ST_BAD_FREE;
      end
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_word(result_word_t got);
      result_word_t exp_r;
      status_seen[got.status]++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d cls=%0d blk=%0d off=%h, got st=%0d cls=%0d blk=%0d off=%h",
                   exp_r.status, exp_r.cls, exp_r.blk, exp_r.offset,
                   got.status, got.cls, got.blk, got.offset);
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic               cfg_index_i = 0;
  logic [OFF_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = '0;
  logic [REQ_W-1:0]   request_bytes_i = '0;
  logic [CLS_W-1:0]   class_number_i = '0;
  logic [BLK_W-1:0]   block_number_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [2:0]         status_o;
  logic [CLS_W-1:0]   granted_class_o;
  logic [BLK_W-1:0]   granted_block_o;
  logic [OFF_W-1:0]   byte_offset_o;

  alloc_scoreboard sb = new();
  bit hold_req = 0;        // asks the receiver for one long hold-off
  int cycles = 0;
  int words_sent = 0;
  int phases_run = 0;

  // blocks handed out and not yet returned, packed as {class, block}
  logic [12:0] live_blocks [$];

  size_class_block_allocator dut (.*);

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor, checks every accepted result word in order
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({status_o, granted_class_o, granted_block_o, byte_offset_o});

  // receiver: random stall at a randomly chosen rate, with one long hold when asked
  initial begin
    int mode, pct;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (cycles % 32 == 0) mode = $urandom_range(0, 3);
        pct = (mode == 0) ? 0 : (mode == 1) ? 25 : (mode == 2) ? 50 : 80;
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // drives one word and returns at the edge it is taken; valid is left high
  task automatic send_word(logic [1:0] op, logic [31:0] req, logic [2:0] cls,
                           logic [9:0] blk);
    result_word_t r;
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    request_bytes_i <= req;
    class_number_i  <= cls;
    block_number_i  <= blk;
    do @(posedge clk_i); while (in_stall_o);
    r = sb.note_word(op, req, cls, blk);
    words_sent++;
    if (op == OP_REBUILD) live_blocks.delete();
    if (op == OP_ALLOC && r.status == ST_GRANTED) live_blocks.push_back({r.cls, r.blk});
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // sender pause until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only ever called with the block idle
  task automatic write_reg(logic idx, logic [OFF_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // one random word: mostly allocs that fit some class and frees of live blocks
  task automatic random_word();
    int pick, k, idx;
    logic [31:0] req;
    logic [12:0] lb;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      k = $urandom_range(0, NUM_CLASSES - 1);
      case ($urandom_range(0, 5))
        0: req = 32'd1 << (MIN_CLASS_SHIFT + k);
        1: req = (32'd1 << (MIN_CLASS_SHIFT + k)) + 1;
        2: req = $urandom;
        3: req = $urandom_range(0, 3);
        default: req = $urandom_range(1, 32'd1 << (MIN_CLASS_SHIFT + k));
      endcase
      send_word(OP_ALLOC, req, $urandom, $urandom);
    end else if (pick < 88 && live_blocks.size() != 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      lb = live_blocks[idx];
      // now and then leave it in the list so it gets freed twice
      if ($urandom_range(0, 9) != 0) live_blocks.delete(idx);
      send_word(OP_FREE, $urandom, lb[12:10], lb[9:0]);
    end else if (pick < 96) begin
      send_word(OP_FREE, $urandom, $urandom_range(0, 7), $urandom);
    end else if (pick < 98) begin
      send_word(OP_REBUILD, $urandom, $urandom, $urandom);
    end else begin
      send_word(2'd3, $urandom, $urandom, $urandom);
    end
  endtask

  // bursts of random length with random gaps, some stretches gap-free
  task automatic random_traffic(int n_words);
    int done_words, burst;
    bit no_gaps;
    done_words = 0;
    no_gaps = 0;
    while (done_words < n_words) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      for (int i = 0; i < burst && done_words < n_words; i++) begin
        random_word();
        done_words++;
      end
      if (!no_gaps) idle_cycles($urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  task automatic run_phase(logic [OFF_W-1:0] total, logic [31:0] maxb, int n_words);
    drain();
    write_reg(CFG_ARENA_TOTAL, total);
    write_reg(CFG_MAX_BLOCK, {8'd0, maxb});
    send_word(OP_REBUILD, $urandom, $urandom, $urandom);
    random_traffic(n_words);
    phases_run++;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: everything rejected while disabled, then default registers
    send_word(OP_ALLOC, 32'd100, '0, '0);
    send_word(OP_FREE, '0, '0, '0);
    send_word(2'd3, '0, '0, '0);
    send_word(OP_REBUILD, '0, '0, '0);      // total still zero, stays disabled
    send_word(OP_ALLOC, 32'd100, '0, '0);
    drain();

    // 4 MiB per class: 64 blocks of 64 KiB down to 2 blocks of 2 MiB
    write_reg(CFG_ARENA_TOTAL, 40'd25165824);
    send_word(OP_REBUILD, '0, '0, '0);
    send_word(OP_ALLOC, 32'd0, '0, '0);
    send_word(OP_ALLOC, 32'd1, '0, '0);
    send_word(OP_ALLOC, 32'd65536, '0, '0);
    send_word(OP_ALLOC, 32'd65537, '0, '0);
    send_word(OP_ALLOC, 32'd2097153, '0, '0);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
    // empty the top class, then one more for exhaustion
    repeat (3) send_word(OP_ALLOC, 32'd2097152, '0, '0);
    send_word(OP_FREE, '0, 3'd5, 10'd1);
    send_word(OP_FREE, '0, 3'd5, 10'd0);
    send_word(OP_FREE, '0, 3'd5, 10'd0);    // stack already full
    send_word(OP_FREE, '0, 3'd6, 10'd0);    // class not active
    send_word(OP_FREE, '0, 3'd7, 10'h3FF);
    send_word(OP_FREE, '0, 3'd0, 10'h3FF);  // block beyond class count
    drain();

    // max of zero, max below the smallest class, total giving no blocks
    run_phase(40'd1048576, 32'd0, 6);
    run_phase(40'd1048576, 32'd65535, 6);
    run_phase(40'd1, 32'd2097152, 6);
    // single class, tight arena so it runs dry
    run_phase(40'd196608, 32'd65536, 30);

    // long receiver hold while the sender keeps offering words
    drain();
    hold_req = 1;
    for (int i = 0; i < 20; i++) random_word();
    drain();

    // both registers at their top values, every class saturated
    run_phase(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 60);
    // small random layouts, plus a tight one where exhaustion is common
    run_phase(40'd1179648, 32'd2097152, 60);
    for (int p = 0; p < 5; p++)
      run_phase(40'($urandom_range(1, 2000)) << 16,
                (32'd1 << $urandom_range(15, 23)) + $urandom_range(0, 1), 45);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.pending_q.size() != 0) sb.mismatches++;
    $display("%0d words over %0d register settings; granted %0d, exhausted %0d, oversize %0d,",
             words_sent, phases_run, sb.status_seen[ST_GRANTED], sb.status_seen[ST_EXHAUSTED],
             sb.status_seen[ST_OVERSIZE]);
    $display("freed %0d, bad frees %0d, rebuilds %0d; %0d mismatches",
             sb.status_seen[ST_FREED], sb.status_seen[ST_BAD_FREE],
             sb.status_seen[ST_REBUILT], sb.mismatches);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== size_class_block_allocator.f =====
+incdir+rtl/core
rtl/core/scba_pkg.sv
rtl/core/scba_ram.sv
rtl/core/scba_ctrl.sv
rtl/core/scba_datapath.sv
rtl/core/size_class_block_allocator.sv
rtl/core/scba_checker.sv
tb/tb.sv
